### rtl/fcce_pkg.sv
package fcce_pkg;

   localparam int SIGNAL_DEPTH = 1024;
   localparam int PATCH_DEPTH  = 256;
   localparam int SAMPLE_BITS  = 16;

   localparam int SUM_BITS  = 40;
   localparam int ADDR_BITS = 4;
   localparam int DATA_BITS = 32;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   // Action codes of an input item.
   localparam logic [1:0] ACT_SIGNAL_WR = 2'd0;
   localparam logic [1:0] ACT_PATCH_WR  = 2'd1;
   localparam logic [1:0] ACT_QUERY     = 2'd2;

   // Register indexes (byte address is four times the index).
   localparam logic [1:0] REG_MODE       = 2'd0;
   localparam logic [1:0] REG_SIGNAL_LEN = 2'd1;
   localparam logic [1:0] REG_PATCH_LEN  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [10:0]        position;
      logic signed [15:0] sample;
   } req_payload_type;

   typedef struct packed {
      logic signed [SUM_BITS-1:0] sum_value;
      logic                       out_of_range;
   } rsp_payload_type;

   typedef struct packed {
      logic        correlate_mode;
      logic [10:0] signal_length;
      logic [8:0]  patch_length;
   } cfg_type;

endpackage

### rtl/fcce_ram.sv
module fcce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/fcce_csr.sv
module fcce_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [fcce_pkg::ADDR_BITS-1:0]       paddr,
   input  logic [fcce_pkg::DATA_BITS-1:0]       pwdata,
   output logic [fcce_pkg::DATA_BITS-1:0]       prdata,
   output logic                                 pready,
   output fcce_pkg::cfg_type                    cfg
);

   fcce_pkg::cfg_type cfg_ff;
   fcce_pkg::cfg_type cfg_in;
   logic              wr_fire;
   logic [1:0]        reg_index;

   assign wr_fire   = psel && penable && pwrite;
   assign reg_index = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         unique case (reg_index)
            fcce_pkg::REG_MODE:       cfg_in.correlate_mode = pwdata[0];
            fcce_pkg::REG_SIGNAL_LEN: cfg_in.signal_length  = pwdata[10:0];
            fcce_pkg::REG_PATCH_LEN:  cfg_in.patch_length   = pwdata[8:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.correlate_mode <= 1'b0;
         cfg_ff.signal_length  <= 11'd1;
         cfg_ff.patch_length   <= 9'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         fcce_pkg::REG_MODE:       prdata = {31'd0, cfg_ff.correlate_mode};
         fcce_pkg::REG_SIGNAL_LEN: prdata = {21'd0, cfg_ff.signal_length};
         fcce_pkg::REG_PATCH_LEN:  prdata = {23'd0, cfg_ff.patch_length};
         default:                  prdata = '0;
      endcase
   end

   assign pready = 1'b1;
   assign cfg    = cfg_ff;

endmodule

### rtl/fcce_engine.sv
module fcce_engine #(
   parameter int SIGNAL_DEPTH = fcce_pkg::SIGNAL_DEPTH,
   parameter int PATCH_DEPTH  = fcce_pkg::PATCH_DEPTH,
   parameter int SAMPLE_BITS  = fcce_pkg::SAMPLE_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  fcce_pkg::cfg_type         cfg,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fcce_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fcce_pkg::rsp_payload_type rsp_payload
);

   localparam int SA = (SIGNAL_DEPTH > 1) ? $clog2(SIGNAL_DEPTH) : 1;
   localparam int PA = (PATCH_DEPTH > 1) ? $clog2(PATCH_DEPTH) : 1;
   localparam int PB = 2 * SAMPLE_BITS;
   localparam int GROWN = PB + $clog2(PATCH_DEPTH + 1) + 1;
   localparam int ACC_BITS = (GROWN > fcce_pkg::SUM_BITS) ? GROWN : fcce_pkg::SUM_BITS + 1;
   localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'(fcce_pkg::SUM_MAX);
   localparam logic signed [ACC_BITS-1:0] SAT_LO = ACC_BITS'(fcce_pkg::SUM_MIN);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } eng_state_type;

   eng_state_type state_ff, state_in;

   logic [8:0]                 k_ff, k_in;
   logic signed [12:0]         j_ff, j_in;
   logic [10:0]                slen_ff, slen_in;
   logic [8:0]                 plen_ff, plen_in;
   logic                       s1_live_ff, s1_live_in;
   logic                       s1_use_ff, s1_use_in;
   logic                       s2_live_ff, s2_live_in;
   logic signed [PB-1:0]       prod_ff, prod_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;
   logic                       oor_ff, oor_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   fcce_pkg::rsp_payload_type  rsp_ff, rsp_in;

   logic                   accept;
   logic                   sig_we, pat_we;
   logic [SAMPLE_BITS-1:0] wr_sample;
   logic [SAMPLE_BITS-1:0] sig_rd, pat_rd;
   logic [10:0]            slen_cfg;
   logic [8:0]             plen_cfg;
   logic [11:0]            total;
   logic                   j_in_signal;
   logic                   rsp_free;
   logic signed [fcce_pkg::SUM_BITS-1:0] sat_sum;

   assign accept   = req_valid && req_ready;
   assign sig_we   = accept && (req_payload.action == fcce_pkg::ACT_SIGNAL_WR)
                     && (32'(req_payload.position) < SIGNAL_DEPTH);
   assign pat_we   = accept && (req_payload.action == fcce_pkg::ACT_PATCH_WR)
                     && (32'(req_payload.position) < PATCH_DEPTH);

   // The stored sample keeps the low bits of the field; a wider one is sign extended.
   if (SAMPLE_BITS <= 16) begin : g_narrow
      assign wr_sample = req_payload.sample[SAMPLE_BITS-1:0];
   end else begin : g_wide
      assign wr_sample = SAMPLE_BITS'(req_payload.sample);
   end

   fcce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SIGNAL_DEPTH)) u_signal_ram (
      .clock   (clock),
      .wr_en   (sig_we),
      .wr_addr (SA'(req_payload.position)),
      .wr_data (wr_sample),
      .rd_addr (SA'(j_ff)),
      .rd_data (sig_rd)
   );

   fcce_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(PATCH_DEPTH)) u_patch_ram (
      .clock   (clock),
      .wr_en   (pat_we),
      .wr_addr (PA'(req_payload.position)),
      .wr_data (wr_sample),
      .rd_addr (PA'(k_ff)),
      .rd_data (pat_rd)
   );

   // Lengths in use saturate at the store depths.
   assign slen_cfg = (32'(cfg.signal_length) > SIGNAL_DEPTH) ? 11'(SIGNAL_DEPTH)
                                                             : cfg.signal_length;
   assign plen_cfg = (32'(cfg.patch_length) > PATCH_DEPTH) ? 9'(PATCH_DEPTH)
                                                           : cfg.patch_length;
   assign total    = (slen_cfg == 11'd0 && plen_cfg == 9'd0) ? 12'd0
                     : {1'b0, slen_cfg} + {3'd0, plen_cfg} - 12'd1;

   assign j_in_signal = (j_ff >= 13'sd0) && (j_ff < $signed({2'b00, slen_ff}));
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready   = (state_ff == ST_IDLE);

   always_comb begin
      prod_in = '0;
      if (s1_use_ff) begin
         prod_in = $signed(sig_rd) * $signed(pat_rd);
      end
   end

   assign sat_sum = (acc_ff > SAT_HI) ? fcce_pkg::SUM_MAX
                  : (acc_ff < SAT_LO) ? fcce_pkg::SUM_MIN
                  : acc_ff[fcce_pkg::SUM_BITS-1:0];

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      slen_in      = slen_ff;
      plen_in      = plen_ff;
      oor_in       = oor_ff;
      acc_in       = s2_live_ff ? acc_ff + ACC_BITS'(prod_ff) : acc_ff;
      s1_live_in   = 1'b0;
      s1_use_in    = 1'b0;
      s2_live_in   = s1_live_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_payload.action == fcce_pkg::ACT_QUERY) begin
               slen_in = slen_cfg;
               plen_in = plen_cfg;
               k_in    = 9'd0;
               acc_in  = '0;
               oor_in  = ({1'b0, req_payload.position} >= total);
               if (cfg.correlate_mode) begin
                  j_in = $signed({2'b00, req_payload.position})
                         - $signed({4'b0000, plen_cfg}) + 13'sd1;
               end else begin
                  j_in = $signed({2'b00, req_payload.position});
               end
               if (oor_in || plen_cfg == 9'd0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // One product term is read from both stores each cycle.
            s1_live_in = 1'b1;
            s1_use_in  = j_in_signal;
            k_in       = k_ff + 9'd1;
            j_in       = cfg.correlate_mode ? j_ff + 13'sd1 : j_ff - 13'sd1;
            if (k_ff == plen_ff - 9'd1) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_live_ff && !s2_live_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.sum_value    = oor_ff ? '0 : sat_sum;
               rsp_in.out_of_range = oor_ff;
               state_in            = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         s1_live_ff   <= 1'b0;
         s2_live_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_live_ff   <= s1_live_in;
         s2_live_ff   <= s2_live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      j_ff      <= j_in;
      slen_ff   <= slen_in;
      plen_ff   <= plen_in;
      oor_ff    <= oor_in;
      acc_ff    <= acc_in;
      s1_use_ff <= s1_use_in;
      prod_ff   <= prod_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/full_convolution_correlation_engine.sv
// Full convolution / cross-correlation engine.
// Items arrive on the req_ channel (valid/ready). A signal write or patch write
// stores one sample in the signal or patch memory, unless its position is past the
// memory depth, and yields no result; such items are taken one per cycle while the
// engine is idle. A query names an output position and yields one item on the rsp_
// channel: the exact sum, saturated to 40 bits, or zero with out_of_range set when
// the position is at or past signal_length + patch_length - 1. A query runs one
// multiply-accumulate per patch sample, reading one word from each memory per cycle.
// An in-range query passes through the run, drain and finish states; an out-of-range
// query, or one with a patch length of zero, goes straight to the finish state.
// The result sits in an output register: the engine takes new items while it waits.
// If the receiver stalls, a query that finishes holds its sum and req_ready stays low
// until the previous result has been taken.
// Reset clears the control state and sets the registers to convolution mode with
// both lengths one; memory contents are not cleared and must be written before use.
// Registers sit on the APB port at byte addresses 0 (mode), 4 and 8 (lengths);
// write them only while the engine is idle.
module full_convolution_correlation_engine #(
   parameter int SIGNAL_DEPTH = fcce_pkg::SIGNAL_DEPTH,
   parameter int PATCH_DEPTH  = fcce_pkg::PATCH_DEPTH,
   parameter int SAMPLE_BITS  = fcce_pkg::SAMPLE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  fcce_pkg::req_payload_type      req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output fcce_pkg::rsp_payload_type      rsp_payload,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fcce_pkg::ADDR_BITS-1:0] paddr,
   input  logic [fcce_pkg::DATA_BITS-1:0] pwdata,
   output logic [fcce_pkg::DATA_BITS-1:0] prdata,
   output logic                           pready
);

   fcce_pkg::cfg_type cfg;

   fcce_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fcce_engine #(
      .SIGNAL_DEPTH (SIGNAL_DEPTH),
      .PATCH_DEPTH  (PATCH_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### rtl/fcce_checker.sv
module fcce_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input fcce_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input fcce_pkg::rsp_payload_type rsp_payload
);

   // A result waiting for the receiver stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("result item changed while stalled");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_of_range |-> rsp_payload.sum_value == '0)
      else $error("out-of-range result carries a nonzero sum");

   // A query occupies the engine, so nothing else is taken right after it.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.action == fcce_pkg::ACT_QUERY |=> !req_ready)
      else $error("item taken while a query is in progress");

   // Writes never produce a result.
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.action != fcce_pkg::ACT_QUERY
      |=> !$rose(rsp_valid))
      else $error("result item appeared after a write");

endmodule

bind full_convolution_correlation_engine fcce_checker u_fcce_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
